// ===== design/fct_pkg.sv =====
package fct_pkg;
  localparam int TableDepth = 128;
  localparam int TopN = 10;
  localparam int QueueDepth = 2;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int RankW = $clog2(TopN + 1);
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthIpv6 = 16'h86DD;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoIcmp6 = 8'd58;
  localparam logic [2:0] KindTcp4 = 3'd0;
  localparam logic [2:0] KindUdp4 = 3'd1;
  localparam logic [2:0] KindIcmp4 = 3'd2;
  localparam logic [2:0] KindTcp6 = 3'd3;
  localparam logic [2:0] KindUdp6 = 3'd4;
  localparam logic [2:0] KindIcmp6 = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [63:0] sh;
    logic [63:0] sl;
    logic [63:0] dh;
    logic [63:0] dl;
    logic [31:0] ports;
  } key_t;

  // key 32+64*4+3 bits, counters 48+32+48+32
  localparam int KeyW = $bits(key_t);
  localparam int CtrW = 160;

  typedef struct packed {
    logic tick;
    key_t key;
    logic [15:0] len;
  } cmd_t;

  typedef struct packed {
    logic [47:0] rxb;
    logic [31:0] rxp;
    logic [47:0] txb;
    logic [31:0] txp;
  } ctr_t;

  typedef struct packed {
    key_t key;
    ctr_t ctr;
    logic last;
  } res_t;
endpackage

// ===== design/fct_ram.sv =====
module fct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/fct_front.sv =====
module fct_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           kind,
  input  logic [15:0]    ethertype,
  input  logic [7:0]     ip_protocol,
  input  logic [63:0]    src_addr_high,
  input  logic [63:0]    src_addr_low,
  input  logic [63:0]    dst_addr_high,
  input  logic [63:0]    dst_addr_low,
  input  logic [15:0]    src_l4_port,
  input  logic [15:0]    dst_l4_port,
  input  logic [15:0]    frame_length,
  output logic           q_valid,
  output fct_pkg::cmd_t  q_cmd,
  input  logic           q_take
);
  import fct_pkg::*;
  cmd_t qmem [QueueDepth];
  logic rp, wp;
  logic [1:0] cnt;
  logic [2:0] k;
  logic ok, v4, icmp;
  cmd_t c;
  logic acc;

  always_comb begin
    ok = 1'b1;
    k = KindTcp4;
    if (ethertype == EthIpv4) begin
      case (ip_protocol)
        ProtoTcp: k = KindTcp4;
        ProtoUdp: k = KindUdp4;
        ProtoIcmp: k = KindIcmp4;
        default: ok = 1'b0;
      endcase
    end else if (ethertype == EthIpv6) begin
      case (ip_protocol)
        ProtoTcp: k = KindTcp6;
        ProtoUdp: k = KindUdp6;
        ProtoIcmp6: k = KindIcmp6;
        default: ok = 1'b0;
      endcase
    end else begin
      ok = 1'b0;
    end
    v4 = (k == KindTcp4) || (k == KindUdp4) || (k == KindIcmp4);
    icmp = (k == KindIcmp4) || (k == KindIcmp6);
    c.tick = kind;
    c.len = frame_length;
    c.key.kind = k;
    c.key.sh = v4 ? 64'd0 : src_addr_high;
    c.key.dh = v4 ? 64'd0 : dst_addr_high;
    c.key.sl = v4 ? {32'd0, src_addr_low[31:0]} : src_addr_low;
    c.key.dl = v4 ? {32'd0, dst_addr_low[31:0]} : dst_addr_low;
    c.key.ports = icmp ? 32'd0 : {src_l4_port, dst_l4_port};
  end

  assign full = (cnt == 2'(QueueDepth));
  assign acc = push && !full && (kind || ok);
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = qmem[rp];

  always_ff @(posedge clk) begin
    if (acc) begin
      qmem[wp] <= c;
    end
    if (rst) begin
      rp <= 1'b0;
      wp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) begin
        wp <= ~wp;
      end
      if (q_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(acc) - 2'(q_take);
    end
  end
endmodule

// ===== design/fct_back.sv =====
module fct_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           sort_key,
  input  logic           q_valid,
  input  fct_pkg::cmd_t  q_cmd,
  output logic           q_take,
  output logic           r_valid,
  output fct_pkg::res_t  r_data,
  input  logic           r_take
);
  import fct_pkg::*;
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SCAN = 8'b00000010,
    S_PKT  = 8'b00000100,
    S_UPD  = 8'b00001000,
    S_RANK = 8'b00010000,
    S_RLST = 8'b00100000,
    S_EMIT = 8'b01000000,
    S_EWT  = 8'b10000000
  } st_t;
  st_t st;
  cmd_t cur;
  logic [CntW-1:0] count, idx;
  logic [IdxW-1:0] raddr, waddr, best, hit;
  logic [RankW-1:0] rank, emit_n;
  logic we;
  logic [KeyW-1:0] kw, kr;
  logic [CtrW-1:0] cw, cr;
  key_t rk;
  ctr_t rc, nc;
  logic have_prev;
  logic [47:0] prev_v;
  logic [IdxW-1:0] prev_idx;
  logic found, is_rx, have_best, rvalid_d;
  logic [IdxW-1:0] rd_idx;
  logic [47:0] bestv, v;
  logic fwd_m, rev_m;
  logic [48:0] sb;
  logic [32:0] sp;

  fct_ram #(.Width(KeyW), .Depth(TableDepth)) u_key (
    .clk, .we, .waddr, .wdata(kw), .raddr, .rdata(kr));
  fct_ram #(.Width(CtrW), .Depth(TableDepth)) u_ctr (
    .clk, .we, .waddr, .wdata(cw), .raddr, .rdata(cr));

  assign rk = key_t'(kr);
  assign rc = ctr_t'(cr);
  assign v = sort_key ? {16'd0, rc.rxp} : rc.rxb;
  assign fwd_m = (rk == cur.key);
  assign rev_m = rk.kind == cur.key.kind && rk.sh == cur.key.dh && rk.sl == cur.key.dl
    && rk.dh == cur.key.sh && rk.dl == cur.key.sl
    && rk.ports == {cur.key.ports[15:0], cur.key.ports[31:16]};
  assign q_take = (st == S_IDLE) && q_valid;
  assign raddr = (st == S_PKT && found) ? hit : idx[IdxW-1:0];

  always_comb begin
    nc = rc;
    if (is_rx) begin
      sb = {1'b0, rc.rxb} + 49'(cur.len);
      sp = {1'b0, rc.rxp} + 33'd1;
      nc.rxb = sb[48] ? '1 : sb[47:0];
      nc.rxp = sp[32] ? '1 : sp[31:0];
    end else begin
      sb = {1'b0, rc.txb} + 49'(cur.len);
      sp = {1'b0, rc.txp} + 33'd1;
      nc.txb = sb[48] ? '1 : sb[47:0];
      nc.txp = sp[32] ? '1 : sp[31:0];
    end
    we = 1'b0;
    waddr = hit;
    kw = cur.key;
    cw = nc;
    if (st == S_UPD) begin
      we = 1'b1;
      kw = rk;
    end else if (st == S_PKT && !found && count < CntW'(TableDepth)) begin
      we = 1'b1;
      waddr = count[IdxW-1:0];
      cw = {48'(cur.len), 32'd1, 48'd0, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    rvalid_d <= (st == S_SCAN || st == S_RANK) && idx < count;
    rd_idx <= raddr;
    if (rst) begin
      st <= S_IDLE;
      count <= '0;
      r_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (r_take && st != S_EWT) begin
        r_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_cmd;
            idx <= '0;
            found <= 1'b0;
            is_rx <= 1'b0;
            have_best <= 1'b0;
            have_prev <= 1'b0;
            rank <= '0;
            emit_n <= (count < CntW'(TopN)) ? RankW'(count) : RankW'(TopN);
            if (q_cmd.tick) begin
              if (count == '0) st <= S_IDLE;
              else st <= S_RANK;
            end else begin
              st <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx < count) idx <= idx + 1'b1;
          if (rvalid_d) begin
            if (fwd_m) begin
              hit <= rd_idx;
              found <= 1'b1;
              is_rx <= 1'b1;
            end else if (rev_m && !is_rx && !found) begin
              hit <= rd_idx;
              found <= 1'b1;
            end
          end
          if (!(idx < count) && !rvalid_d) st <= S_PKT;
        end
        S_PKT: begin
          if (found) begin
            idx <= CntW'(hit);
            st <= S_UPD;
          end else begin
            if (count < CntW'(TableDepth)) count <= count + 1'b1;
            st <= S_IDLE;
          end
        end
        S_UPD: st <= S_IDLE;
        S_RANK: begin
          if (idx < count) idx <= idx + 1'b1;
          // only flows ranked below the previous report are candidates
          if (rvalid_d
              && (!have_prev || v < prev_v || (v == prev_v && rd_idx > prev_idx))
              && (!have_best || v > bestv)) begin
            best <= rd_idx;
            bestv <= v;
            have_best <= 1'b1;
          end
          if (!(idx < count) && !rvalid_d) st <= S_RLST;
        end
        S_RLST: begin
          idx <= CntW'(best);
          st <= S_EMIT;
        end
        S_EMIT: st <= S_EWT;
        S_EWT: begin
          if (!r_valid || r_take) begin
            r_valid <= 1'b1;
            r_data.key <= rk;
            r_data.ctr <= rc;
            r_data.last <= (rank + 1'b1 == emit_n);
            prev_v <= bestv;
            prev_idx <= best;
            have_prev <= 1'b1;
            rank <= rank + 1'b1;
            have_best <= 1'b0;
            idx <= '0;
            if (rank + 1'b1 == emit_n) begin
              count <= '0;
              st <= S_IDLE;
            end else begin
              st <= S_RANK;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/flow_counter_table_top_n_top.sv =====
// Flow counter table, 128 flows, top 10 report on tick. For a packet the key
// memory is scanned one entry a cycle, then a hit does one counter
// read-modify-write and a miss writes a new entry while the table has room.
// A tick does one full scan of the table per rank. A two-entry queue parts
// input from the table engine; the report register waits on pop.
module flow_counter_table_top_n_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [15:0] ethertype,
  input  logic [7:0]  ip_protocol,
  input  logic [63:0] src_addr_high,
  input  logic [63:0] src_addr_low,
  input  logic [63:0] dst_addr_high,
  input  logic [63:0] dst_addr_low,
  input  logic [15:0] src_l4_port,
  input  logic [15:0] dst_l4_port,
  input  logic [15:0] frame_length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  flow_kind,
  output logic [63:0] out_src_high,
  output logic [63:0] out_src_low,
  output logic [63:0] out_dst_high,
  output logic [63:0] out_dst_low,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [47:0] receive_bytes,
  output logic [31:0] receive_packets,
  output logic [47:0] transmit_bytes,
  output logic [31:0] transmit_packets,
  output logic        last
);
  import fct_pkg::*;
  logic sort_key, q_valid, q_take, r_valid;
  cmd_t q_cmd;
  res_t r_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= 1'b0;
    end else if (cfg_we) begin
      sort_key <= cfg_wdata;
    end
  end

  fct_front u_front (.clk, .rst, .push, .full, .kind, .ethertype, .ip_protocol,
    .src_addr_high, .src_addr_low, .dst_addr_high, .dst_addr_low, .src_l4_port,
    .dst_l4_port, .frame_length, .q_valid, .q_cmd, .q_take);

  fct_back u_back (.clk, .rst, .sort_key, .q_valid, .q_cmd, .q_take,
    .r_valid, .r_data, .r_take(pop && r_valid));

  assign empty = !r_valid;
  assign flow_kind = r_data.key.kind;
  assign out_src_high = r_data.key.sh;
  assign out_src_low = r_data.key.sl;
  assign out_dst_high = r_data.key.dh;
  assign out_dst_low = r_data.key.dl;
  assign out_src_port = r_data.key.ports[31:16];
  assign out_dst_port = r_data.key.ports[15:0];
  assign receive_bytes = r_data.ctr.rxb;
  assign receive_packets = r_data.ctr.rxp;
  assign transmit_bytes = r_data.ctr.txb;
  assign transmit_packets = r_data.ctr.txp;
  assign last = r_data.last;
endmodule

// ===== design/fct_checker.sv =====
module fct_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  flow_kind,
  input logic [31:0] receive_packets
);
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");
  a_kind: assert property (@(posedge clk) disable iff (rst) !empty |-> flow_kind <= 3'd5)
    else $error("bad flow kind");
  a_pkts: assert property (@(posedge clk) disable iff (rst)
    !empty |-> receive_packets != 32'd0)
    else $error("flow without receive packet");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(flow_kind))
    else $error("result changed while waiting");
endmodule

bind flow_counter_table_top_n_top fct_checker u_chk (.clk, .rst, .empty, .pop,
  .flow_kind, .receive_packets);
